/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the band contrast colour picker.
// Each macro checks a clocked implication, with reset masking the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, clk, rst, a, c, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, a, c, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* hw/rtl/bctc_pkg.sv */
// Package for the band contrast text colour picker: types, codes, luma table.
// No dependencies.
`timescale 1ns / 1ps

package bctc_pkg;

  localparam int DEF_MAX_SAMPLES = 65536;

  localparam int QUOT_W = 8;   // every quotient here is below 256
  localparam int PCT_W  = 7;
  localparam int LUMA_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [2:0] MODE_COLOUR       = 3'd0;
  localparam logic [2:0] MODE_MONO         = 3'd1;
  localparam logic [2:0] MODE_EMPTY_COLOUR = 3'd2;
  localparam logic [2:0] MODE_EMPTY_MONO   = 3'd3;
  localparam logic [2:0] MODE_CLEAR        = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_BAD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_BAD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSSOVER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALO_PCT  = 3'd4;

  localparam logic [7:0]       RST_WHITE_BAD  = 8'd200;
  localparam logic [7:0]       RST_BLACK_BAD  = 8'd50;
  localparam logic [7:0]       RST_CROSSOVER  = 8'd128;
  localparam logic [PCT_W-1:0] RST_HYSTERESIS = 7'd10;
  localparam logic [PCT_W-1:0] RST_HALO_PCT   = 7'd20;

  localparam logic [LUMA_W-1:0] LUMA_WHITE = 8'd255;
  localparam logic [LUMA_W-1:0] LUMA_BLACK = 8'd0;

  localparam logic [LUMA_W-1:0] LUMA_ROM [0:63] = '{
    8'd0,   8'd3,   8'd15,  8'd36,  8'd14,  8'd18,  8'd28,  8'd49,
    8'd65,  8'd69,  8'd80,  8'd100, 8'd160, 8'd165, 8'd175, 8'd195,
    8'd5,   8'd8,   8'd19,  8'd39,  8'd20,  8'd23,  8'd34,  8'd54,
    8'd71,  8'd74,  8'd85,  8'd105, 8'd167, 8'd170, 8'd181, 8'd201,
    8'd25,  8'd28,  8'd39,  8'd59,  8'd39,  8'd42,  8'd53,  8'd73,
    8'd90,  8'd94,  8'd104, 8'd125, 8'd185, 8'd189, 8'd201, 8'd219,
    8'd60,  8'd62,  8'd74,  8'd94,  8'd74,  8'd77,  8'd87,  8'd108,
    8'd125, 8'd129, 8'd140, 8'd160, 8'd218, 8'd223, 8'd234, 8'd255
  };

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] sample;
    logic       end_of_band;
  } bctc_in_t;

  typedef struct packed {
    logic              result_valid;
    logic              use_white;
    logic              halo;
    logic [PCT_W-1:0]  bad_pct;
    logic [PCT_W-1:0]  bad_white_pct;
    logic [PCT_W-1:0]  bad_black_pct;
    logic [LUMA_W-1:0] mean_luma;
  } bctc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DECIDE,
    ST_EMIT
  } bctc_state_t;

  typedef enum logic [1:0] {
    DIV_WHITE,
    DIV_BLACK,
    DIV_MEAN
  } div_sel_t;

  typedef struct packed {
    logic     acc_en;      // accumulate the accepted sample
    logic     acc_clr;     // zero the accumulators
    logic     end_latch;   // remember which rule the band end takes
    logic     dec_clr;     // return decision state to reset values
    logic     empty_band;  // empty band request
    logic     div_load;
    div_sel_t div_sel;
    logic     div_latch;   // store the finished quotient
    logic     decide;
    logic     out_load;
  } bctc_cmd_t;

endpackage

/* hw/rtl/bctc_div.sv */
// Restoring divider, one quotient bit per cycle, quotient known to fit QUOT_W.
// Depends on bctc_pkg.
`timescale 1ns / 1ps

module bctc_div
  import bctc_pkg::*;
#(
  parameter int NUM_W = 25,
  parameter int DEN_W = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              busy,
  output logic [QUOT_W-1:0] quot
);

  localparam int CNT_W = $clog2(QUOT_W);

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [CNT_W-1:0] cnt;
  logic             fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QUOT_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // operand has rem < den * 2^QUOT_W, so the top trial starts at den << (QUOT_W-1)
  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= num;
      dsh  <= NUM_W'(den) << (QUOT_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quot <= {quot[QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

endmodule

/* hw/rtl/bctc_dp.sv */
// Datapath: config registers, accumulators, divider, decision and output register.
// Depends on bctc_pkg, bctc_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bctc_dp
  import bctc_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  bctc_in_t             in_data,
  input  bctc_cmd_t            cmd,
  output logic                 div_busy,
  output bctc_out_t            out_data
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = CNT_W + LUMA_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

  logic [7:0]       white_bad_level;
  logic [7:0]       black_bad_level;
  logic [7:0]       crossover_level;
  logic [PCT_W-1:0] hysteresis_points;
  logic [PCT_W-1:0] halo_threshold_pct;

  logic [CNT_W-1:0] sample_count;
  logic [SUM_W-1:0] luma_sum;
  logic [CNT_W-1:0] bright_count;
  logic [CNT_W-1:0] dark_count;
  logic             end_mono;

  logic             decided_flag;
  logic             white_chosen;
  logic             halo_held;
  logic [PCT_W-1:0] held_bad_pct;
  logic [PCT_W-1:0] held_bad_white;
  logic [PCT_W-1:0] held_bad_black;
  logic [7:0]       held_mean;

  logic [LUMA_W-1:0] luma;
  logic              bright;
  logic              dark;
  logic              is_mono;

  logic [SUM_W-1:0]  div_num;
  logic [CNT_W-1:0]  div_den;
  logic [QUOT_W-1:0] quot;

  logic             prefer_white;
  logic [PCT_W-1:0] cur_pct;
  logic [PCT_W-1:0] nxt_pct;
  logic             switch_ok;
  logic             white_next;
  logic [PCT_W-1:0] bad_next;

  logic [CNT_W:0]   class_total;
  logic             class_ok;

  // ---- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      white_bad_level    <= RST_WHITE_BAD;
      black_bad_level    <= RST_BLACK_BAD;
      crossover_level    <= RST_CROSSOVER;
      hysteresis_points  <= RST_HYSTERESIS;
      halo_threshold_pct <= RST_HALO_PCT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WHITE_BAD:  white_bad_level    <= cfg_data;
        CFG_BLACK_BAD:  black_bad_level    <= cfg_data;
        CFG_CROSSOVER:  crossover_level    <= cfg_data;
        CFG_HYSTERESIS: hysteresis_points  <= cfg_data[PCT_W-1:0];
        CFG_HALO_PCT:   halo_threshold_pct <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- sample classification
  assign is_mono = (in_data.mode == MODE_MONO);

  always_comb begin
    if (is_mono) begin
      luma   = in_data.sample[0] ? LUMA_WHITE : LUMA_BLACK;
      bright = in_data.sample[0];
      dark   = !in_data.sample[0];
    end else begin
      luma   = LUMA_ROM[in_data.sample[5:0]];
      bright = luma > white_bad_level;
      dark   = !bright && (luma < black_bad_level);
    end
  end

  // ---- accumulators, saturating at MAX_SAMPLES
  always_ff @(posedge clk) begin
    if (rst || cmd.acc_clr) begin
      sample_count <= '0;
      luma_sum     <= '0;
      bright_count <= '0;
      dark_count   <= '0;
    end else if (cmd.acc_en && (sample_count < MAX_CNT)) begin
      sample_count <= sample_count + 1'b1;
      luma_sum     <= luma_sum + SUM_W'(luma);
      bright_count <= bright_count + CNT_W'(bright);
      dark_count   <= dark_count + CNT_W'(dark);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.end_latch) begin
      end_mono <= is_mono;
    end
  end

  // ---- divider operands; count*100 as shift-add
  always_comb begin
    div_den = (sample_count == '0) ? CNT_W'(1) : sample_count;
    case (cmd.div_sel)
      DIV_WHITE: div_num = (SUM_W'(bright_count) << 6) + (SUM_W'(bright_count) << 5)
                         + (SUM_W'(bright_count) << 2);
      DIV_BLACK: div_num = (SUM_W'(dark_count) << 6) + (SUM_W'(dark_count) << 5)
                         + (SUM_W'(dark_count) << 2);
      DIV_MEAN:  div_num = luma_sum;
      default:   div_num = luma_sum;
    endcase
  end

  bctc_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .load (cmd.div_load),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quot (quot)
  );

  // ---- choice with hysteresis
  always_comb begin
    if (held_bad_white != held_bad_black) begin
      prefer_white = held_bad_white < held_bad_black;
    end else begin
      prefer_white = held_mean < crossover_level;
    end
    cur_pct   = white_chosen ? held_bad_white : held_bad_black;
    nxt_pct   = prefer_white ? held_bad_white : held_bad_black;
    switch_ok = {1'b0, cur_pct} >= ({1'b0, nxt_pct} + {1'b0, hysteresis_points});
    if (!decided_flag) begin
      white_next = prefer_white;
    end else if ((prefer_white != white_chosen) && switch_ok) begin
      white_next = prefer_white;
    end else begin
      white_next = white_chosen;
    end
    bad_next = white_next ? held_bad_white : held_bad_black;
  end

  // quotients land straight in the held percentages and held mean; nothing is emitted mid-division
  always_ff @(posedge clk) begin
    if (rst || cmd.dec_clr) begin
      decided_flag   <= 1'b0;
      white_chosen   <= 1'b1;
      halo_held      <= 1'b0;
      held_bad_pct   <= '0;
      held_bad_white <= '0;
      held_bad_black <= '0;
      held_mean      <= '0;
    end else if (cmd.div_latch) begin
      case (cmd.div_sel)
        DIV_WHITE: held_bad_white <= quot[PCT_W-1:0];
        DIV_BLACK: held_bad_black <= quot[PCT_W-1:0];
        DIV_MEAN:  held_mean      <= quot;
        default: ;
      endcase
    end else if (cmd.decide) begin
      decided_flag <= 1'b1;
      white_chosen <= white_next;
      held_bad_pct <= bad_next;
      halo_held    <= end_mono || (bad_next > halo_threshold_pct);
    end else if (cmd.empty_band) begin
      held_bad_pct <= '0;
      halo_held    <= (in_data.mode == MODE_EMPTY_MONO);
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.result_valid  <= decided_flag;
      out_data.use_white     <= white_chosen;
      out_data.halo          <= halo_held;
      out_data.bad_pct       <= held_bad_pct;
      out_data.bad_white_pct <= held_bad_white;
      out_data.bad_black_pct <= held_bad_black;
      out_data.mean_luma     <= held_mean;
    end
  end

  assign class_total = (CNT_W+1)'(bright_count) + (CNT_W+1)'(dark_count);
  assign class_ok    = class_total <= (CNT_W+1)'(sample_count);

  `ASSERT_IMPL(a_count_limit, clk, rst, 1'b1, sample_count <= MAX_CNT, "sample count past limit")
  `ASSERT_IMPL(a_class_sum, clk, rst, 1'b1, class_ok, "bright plus dark exceeds count")

endmodule

/* hw/rtl/bctc_ctrl.sv */
// Controller: sequences accumulation, three divisions, decision and result hand-off.
// Depends on bctc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bctc_ctrl
  import bctc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  bctc_in_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  logic      div_busy,
  output bctc_cmd_t cmd
);

  bctc_state_t state;
  bctc_state_t state_next;
  div_sel_t    div_idx;
  div_sel_t    div_idx_next;
  logic        out_valid_next;
  logic        in_take;
  logic        is_sample;
  logic        is_empty;
  logic        out_free;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign is_sample = in_data.mode inside {MODE_COLOUR, MODE_MONO};
  assign is_empty  = in_data.mode inside {MODE_EMPTY_COLOUR, MODE_EMPTY_MONO};
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_idx   <= DIV_WHITE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_idx   <= div_idx_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next   = state;
    div_idx_next = div_idx;
    case (state)
      ST_IDLE: begin
        if (in_take && is_sample && in_data.end_of_band) begin
          state_next   = ST_DIV_LOAD;
          div_idx_next = DIV_WHITE;
        end else if (in_take && is_empty) begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV_LOAD: state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (!div_busy) begin
          if (div_idx == DIV_MEAN) begin
            state_next = ST_DECIDE;
          end else begin
            state_next   = ST_DIV_LOAD;
            div_idx_next = (div_idx == DIV_WHITE) ? DIV_BLACK : DIV_MEAN;
          end
        end
      end
      ST_DECIDE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd         = '0;
    cmd.div_sel = div_idx;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          cmd.acc_en     = is_sample;
          cmd.end_latch  = is_sample && in_data.end_of_band;
          cmd.empty_band = is_empty;
          cmd.acc_clr    = is_empty || (in_data.mode == MODE_CLEAR);
          cmd.dec_clr    = (in_data.mode == MODE_CLEAR);
        end
      end
      ST_DIV_LOAD: cmd.div_load = 1'b1;
      ST_DIV_RUN:  cmd.div_latch = !div_busy;
      ST_DECIDE: begin
        cmd.decide  = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      ST_EMIT: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  `ASSERT_NEXT(a_div_started, clk, rst, state == ST_DIV_LOAD, (state == ST_DIV_RUN) && div_busy, "divider did not start")
  `ASSERT_IMPL(a_result_from_emit, clk, rst, $rose(out_valid), $past(state) == ST_EMIT, "result raised outside emit")

endmodule

/* hw/rtl/band_contrast_text_colour_picker.sv */
// Band contrast text colour picker. A sample without an end mark is taken while idle,
// so the input does not stall for it. A band end or empty band is answered once the
// output register is free; the input stalls until the result is in the output register.
// A band end runs three divisions on one shared restoring divider, then decide and
// hand-off; an empty band goes straight to hand-off.
// Synchronous reset returns config, accumulators and decision to defaults at once.
`timescale 1ns / 1ps

module band_contrast_text_colour_picker
  import bctc_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bctc_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bctc_out_t            out_data
);

  bctc_cmd_t cmd;
  logic      div_busy;

  bctc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .div_busy  (div_busy),
    .cmd       (cmd)
  );

  bctc_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .div_busy  (div_busy),
    .out_data  (out_data)
  );

endmodule
